// ===== design/mrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, codes and constants of the modem response matcher.
// ----------------------------------------------------------------------------
package mrm_pkg;

  localparam int MAX_PATTERN_DEF  = 16;
  localparam int BUFFER_CHARS_DEF = 256;

  localparam int PAT_BYTES  = 16;
  localparam int FAIL_LEN   = 11;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0]  QUOTE_CHAR    = 8'h22;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [4:0]  PAT_LEN_RESET = 5'd1;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;

  // FAILED CALL, first character first
  localparam logic [6:0] FAIL_TEXT [FAIL_LEN] = '{
    7'h46, 7'h41, 7'h49, 7'h4C, 7'h45, 7'h44, 7'h20, 7'h43, 7'h41, 7'h4C, 7'h4C
  };

  typedef enum logic [1:0] {
    REQ_CHAR     = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_LINE_ERR = 2'd2,
    REQ_START    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_FOUND    = 3'd1,
    ST_FAILED   = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_LINE_ERR = 3'd4
  } status_t;

  localparam logic [2:0] REG_PAT_LOW  = 3'd0;
  localparam logic [2:0] REG_PAT_HIGH = 3'd1;
  localparam logic [2:0] REG_PAT_LEN  = 3'd2;
  localparam logic [2:0] REG_ONLINE   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
    logic        online_mode;
    logic [15:0] timeout_ticks;
  } cfg_t;

  function automatic logic [7:0] pat_byte(logic [63:0] lo, logic [63:0] hi,
                                          logic [3:0] idx);
    logic [127:0] w;
    w = {hi, lo};
    return w[{idx, 3'b000} +: 8];
  endfunction

  // Pattern length clipped to lim, then cut at the first zero byte
  function automatic logic [4:0] eff_length(logic [63:0] lo, logic [63:0] hi,
                                            logic [4:0] plen, logic [4:0] lim);
    logic [4:0]   len;
    logic [4:0]   res;
    logic [127:0] w;
    w   = {hi, lo};
    len = (plen > lim) ? lim : plen;
    res = len;
    for (int i = PAT_BYTES - 1; i >= 0; i--) begin
      if ((5'(i) < len) && (w[i*8 +: 8] == 8'h00)) res = 5'(i);
    end
    return res;
  endfunction

endpackage

// ===== design/mrm_in_if.sv =====
// ----------------------------------------------------------------------------
// mrm_in_if
// Request channel: one word carries a request type and a received byte.
// ----------------------------------------------------------------------------
interface mrm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_value;

  modport source (output valid, output req_type, output char_value, input ready);
  modport sink   (input valid, input req_type, input char_value, output ready);
endinterface

// ===== design/mrm_out_if.sv =====
// ----------------------------------------------------------------------------
// mrm_out_if
// Result channel: one word carries a status code and the overflow flag.
// ----------------------------------------------------------------------------
interface mrm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       overflow;

  modport source (output valid, output status, output overflow, input ready);
  modport sink   (input valid, input status, input overflow, output ready);
endinterface

// ===== design/mrm_cell.sv =====
// ----------------------------------------------------------------------------
// mrm_cell
// One history position: holds a character, passes it on when the row shifts
// and compares the incoming character against its pattern and text slots.
// ----------------------------------------------------------------------------
module mrm_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  logic       clear,
  input  logic [6:0] char_in,
  input  logic [7:0] pat_char,
  input  logic       pat_act,
  input  logic [6:0] fail_char,
  input  logic       fail_act,
  output logic [6:0] hist_r,
  output logic       pat_ok,
  output logic       fail_ok
);

  logic [6:0] hist_nxt;

  always_comb begin
    hist_nxt = hist_r;
    if (clear) begin
      hist_nxt = '0;
    end else if (shift_en) begin
      hist_nxt = char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  // compare the character this cell takes on the shift
  assign pat_ok  = !pat_act || ({1'b0, char_in} == pat_char);
  assign fail_ok = !fail_act || (char_in == fail_char);

endmodule

// ===== design/mrm_cfg.sv =====
// ----------------------------------------------------------------------------
// mrm_cfg
// APB-style register file holding the pattern, mode and timeout settings.
// ----------------------------------------------------------------------------
module mrm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mrm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mrm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mrm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output mrm_pkg::cfg_t                  cfg
);

  mrm_pkg::cfg_t cfg_r;
  mrm_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        mrm_pkg::REG_PAT_LOW:  cfg_nxt.pattern_low    = pwdata;
        mrm_pkg::REG_PAT_HIGH: cfg_nxt.pattern_high   = pwdata;
        mrm_pkg::REG_PAT_LEN:  cfg_nxt.pattern_length = pwdata[4:0];
        mrm_pkg::REG_ONLINE:   cfg_nxt.online_mode    = pwdata[0];
        mrm_pkg::REG_TIMEOUT:  cfg_nxt.timeout_ticks  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= mrm_pkg::PAT_LEN_RESET;
      cfg_r.online_mode    <= 1'b0;
      cfg_r.timeout_ticks  <= mrm_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      mrm_pkg::REG_PAT_LOW:  prdata = cfg_r.pattern_low;
      mrm_pkg::REG_PAT_HIGH: prdata = cfg_r.pattern_high;
      mrm_pkg::REG_PAT_LEN:  prdata = {59'd0, cfg_r.pattern_length};
      mrm_pkg::REG_ONLINE:   prdata = {63'd0, cfg_r.online_mode};
      mrm_pkg::REG_TIMEOUT:  prdata = {48'd0, cfg_r.timeout_ticks};
      default:               prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== design/modem_response_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// modem_response_matcher_unit
// Streaming match of a modem reply against a configured pattern, with
// call-failed detection, store limit, tick timeout and line error reporting.
// ----------------------------------------------------------------------------
// Every request word returns exactly one result word, one word per clock while
// results are being taken: the received character enters a row of MAX_PATTERN
// history cells, and the active cells compare their next character with the
// pattern and the FAILED CALL text in the same cycle, so the result is registered
// in the cycle after the request is taken. A result register sits between the two
// channels and new requests are taken while the result is being consumed.
// Registers are 64 bits wide at byte addresses 0, 8, 16, 24 and 32; write them
// only while no request is outstanding.
module modem_response_matcher_unit #(
  parameter int MAX_PATTERN  = mrm_pkg::MAX_PATTERN_DEF,
  parameter int BUFFER_CHARS = mrm_pkg::BUFFER_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mrm_in_if.sink                         in_chan,
  mrm_out_if.source                      out_chan,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mrm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mrm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mrm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int CNT_W = $clog2(BUFFER_CHARS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_CHARS);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(BUFFER_CHARS - 1);
  localparam logic [4:0] LEN_LIM =
    5'((MAX_PATTERN < mrm_pkg::PAT_BYTES) ? MAX_PATTERN : mrm_pkg::PAT_BYTES);

  mrm_pkg::cfg_t cfg;

  mrm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  logic [4:0] eff_len;
  assign eff_len = mrm_pkg::eff_length(cfg.pattern_low, cfg.pattern_high,
                                       cfg.pattern_length, LEN_LIM);

  logic             accept;
  logic [6:0]       ch;
  mrm_pkg::req_t    req;
  logic             store;
  logic             restart;

  logic [6:0]             hist    [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pat_ok;
  logic [MAX_PATTERN-1:0] fail_ok;

  assign accept  = in_chan.valid && in_chan.ready;
  assign ch      = in_chan.char_value[6:0];
  assign req     = mrm_pkg::req_t'(in_chan.req_type);

  logic finished_r, finished_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic [15:0] tick_r, tick_nxt, tick_inc;

  assign store   = accept && !finished_r && (req == mrm_pkg::REQ_CHAR) && (ch != 7'd0);
  assign restart = accept && (req == mrm_pkg::REQ_START);

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [6:0] c_in;
    logic [7:0] p_char;
    logic       p_act;
    logic [6:0] f_char;
    logic       f_act;

    if (k == 0) begin : g_head
      assign c_in = ch;
    end else begin : g_link
      assign c_in = hist[k-1];
    end

    if (k < mrm_pkg::PAT_BYTES) begin : g_pat
      logic [4:0] pidx;
      assign pidx   = eff_len - 5'(k + 1);
      assign p_act  = 5'(k) < eff_len;
      assign p_char = mrm_pkg::pat_byte(cfg.pattern_low, cfg.pattern_high, pidx[3:0]);
    end else begin : g_nopat
      assign p_act  = 1'b0;
      assign p_char = '0;
    end

    if (k < mrm_pkg::FAIL_LEN) begin : g_fail
      assign f_act  = 1'b1;
      assign f_char = mrm_pkg::FAIL_TEXT[mrm_pkg::FAIL_LEN - 1 - k];
    end else begin : g_nofail
      assign f_act  = 1'b0;
      assign f_char = '0;
    end

    mrm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_en  (store),
      .clear     (restart),
      .char_in   (c_in),
      .pat_char  (p_char),
      .pat_act   (p_act),
      .fail_char (f_char),
      .fail_act  (f_act),
      .hist_r    (hist[k]),
      .pat_ok    (pat_ok[k]),
      .fail_ok   (fail_ok[k])
    );
  end

  logic       out_v_r, out_v_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic       out_ovf_r, out_ovf_nxt;
  mrm_pkg::status_t status;
  logic       ovf;
  logic       quotes;

  assign count_inc = (count_r < CNT_LIMIT) ? count_r + CNT_W'(1) : count_r;
  assign tick_inc  = (tick_r != mrm_pkg::TICK_MAX) ? tick_r + 16'd1 : tick_r;
  assign quotes    = (eff_len == 5'd2) && (cfg.pattern_low[7:0] == mrm_pkg::QUOTE_CHAR)
                     && (cfg.pattern_low[15:8] == mrm_pkg::QUOTE_CHAR);

  always_comb begin
    status       = mrm_pkg::ST_WAIT;
    ovf          = 1'b0;
    finished_nxt = finished_r;
    count_nxt    = count_r;
    tick_nxt     = tick_r;
    if (accept) begin
      if (req == mrm_pkg::REQ_START) begin
        count_nxt    = '0;
        tick_nxt     = '0;
        finished_nxt = quotes;
        if (quotes) status = mrm_pkg::ST_FOUND;
      end else if (!finished_r) begin
        unique case (req)
          mrm_pkg::REQ_CHAR: begin
            if (ch != 7'd0) begin
              count_nxt = count_inc;
              priority if (&pat_ok) begin
                status = mrm_pkg::ST_FOUND;
              end else if (count_inc >= CNT_FULL) begin
                status = mrm_pkg::ST_FOUND;
                ovf    = 1'b1;
              end else if (cfg.online_mode && (&fail_ok)) begin
                status = mrm_pkg::ST_FAILED;
              end else begin
                status = mrm_pkg::ST_WAIT;
              end
            end
          end
          mrm_pkg::REQ_TICK: begin
            tick_nxt = tick_inc;
            if ((cfg.timeout_ticks != 16'd0) && (tick_inc >= cfg.timeout_ticks)) begin
              status = mrm_pkg::ST_TIMEOUT;
            end
          end
          mrm_pkg::REQ_LINE_ERR: status = mrm_pkg::ST_LINE_ERR;
          mrm_pkg::REQ_START:    status = mrm_pkg::ST_WAIT;
        endcase
        if (status != mrm_pkg::ST_WAIT) finished_nxt = 1'b1;
      end
    end
  end

  // result register: load on accept, drop once taken
  always_comb begin
    out_v_nxt      = out_v_r;
    out_status_nxt = out_status_r;
    out_ovf_nxt    = out_ovf_r;
    if (out_v_r && out_chan.ready) out_v_nxt = 1'b0;
    if (accept) begin
      out_v_nxt      = 1'b1;
      out_status_nxt = status;
      out_ovf_nxt    = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b1;
      count_r    <= '0;
      tick_r     <= '0;
      out_v_r    <= 1'b0;
    end else begin
      finished_r <= finished_nxt;
      count_r    <= count_nxt;
      tick_r     <= tick_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign in_chan.ready     = !out_v_r || out_chan.ready;
  assign out_chan.valid    = out_v_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.overflow = out_ovf_r;

endmodule

// ===== tb/sv/modem_response_matcher_unit_tb.sv =====
// ----------------------------------------------------------------------------
// modem_response_matcher_unit_tb
// Drives request words into the matcher and checks every result word against
// a cycle-free model of the wait: directed corner words first, then random
// waits under several pattern, mode and timeout settings, and the store limit.
// ----------------------------------------------------------------------------
module modem_response_matcher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrm_pkg::*;

  localparam int MAX_PAT     = MAX_PATTERN_DEF;
  localparam int BUF_CHARS   = BUFFER_CHARS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 118;

  typedef enum int {
    SETUP_PLAIN,
    SETUP_TIMEOUT_ONE,
    SETUP_TIMEOUT_MAX,
    SETUP_TIMEOUT_OFF
  } setup_kind_t;

  typedef struct {
    req_t       kind;
    logic [7:0] ch;
  } req_word_t;

  typedef struct {
    status_t status;
    logic    overflow;
  } verdict_t;

  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mrm_in_if  req_if ();
  mrm_out_if res_if ();

  modem_response_matcher_unit #(
    .MAX_PATTERN  (MAX_PAT),
    .BUFFER_CHARS (BUF_CHARS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (req_if),
    .out_chan    (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Mirror of the registers and of the wait in progress
  cfg_t       mirror;
  logic [6:0] seen_chars [MAX_PAT];
  int         stored_n;
  int         ticks_n;
  bit         wait_over;

  req_word_t feed_q [$];
  verdict_t  verdict_q [$];

  int  words_queued;
  int  results_seen;
  int  fail_count;
  int  cycle_n;
  bit  in_fire;
  bit  calm;
  bit  hold_go;
  bit  hold_used;
  int  hold_left;

  logic [7:0] pat_txt [16];
  int         pat_n;
  string      alphabet = "OKATDLINECRG ";

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [7:0] pat_at(int i);
    logic [127:0] w;
    w = {mirror.pattern_high, mirror.pattern_low};
    return w[i*8 +: 8];
  endfunction

  // length cut at the first zero byte of the pattern
  function automatic int live_len();
    int len;
    int res;
    int i;
    len = int'(mirror.pattern_length);
    if (len > MAX_PAT) len = MAX_PAT;
    if (len > 16) len = 16;
    res = len;
    for (i = len - 1; i >= 0; i--) begin
      if (pat_at(i) == 8'h00) res = i;
    end
    return res;
  endfunction

  function automatic bit tail_is_pattern(int len);
    int i;
    if (stored_n == 0 || stored_n < len) return 1'b0;
    for (i = 0; i < len; i++) begin
      if ({1'b0, seen_chars[len-1-i]} != pat_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit tail_is_failed();
    int i;
    if (stored_n < FAIL_LEN) return 1'b0;
    for (i = 0; i < FAIL_LEN; i++) begin
      if (seen_chars[FAIL_LEN-1-i] != FAIL_TEXT[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void clear_wait();
    int i;
    for (i = 0; i < MAX_PAT; i++) seen_chars[i] = 7'h00;
    stored_n = 0;
    ticks_n  = 0;
  endfunction

  function automatic verdict_t match_step(req_t kind, logic [7:0] raw);
    verdict_t   r;
    logic [6:0] c;
    int         len;
    int         i;
    r.status   = ST_WAIT;
    r.overflow = 1'b0;
    c          = raw[6:0];
    if (kind == REQ_START) begin
      clear_wait();
      wait_over = 1'b0;
      if (live_len() == 2 && pat_at(0) == QUOTE_CHAR && pat_at(1) == QUOTE_CHAR) begin
        r.status  = ST_FOUND;
        wait_over = 1'b1;
      end
    end else if (!wait_over) begin
      case (kind)
        REQ_CHAR: begin
          if (c != 7'h00) begin
            for (i = MAX_PAT - 1; i > 0; i--) seen_chars[i] = seen_chars[i-1];
            seen_chars[0] = c;
            if (stored_n < BUF_CHARS) stored_n++;
            len = live_len();
            if (tail_is_pattern(len)) begin
              r.status = ST_FOUND;
            end else if (stored_n >= BUF_CHARS - 1) begin
              r.status   = ST_FOUND;
              r.overflow = 1'b1;
            end else if (mirror.online_mode && tail_is_failed()) begin
              r.status = ST_FAILED;
            end
          end
        end
        REQ_TICK: begin
          if (ticks_n < int'(TICK_MAX)) ticks_n++;
          if (mirror.timeout_ticks != 16'd0 && ticks_n >= int'(mirror.timeout_ticks)) begin
            r.status = ST_TIMEOUT;
          end
        end
        default: r.status = ST_LINE_ERR;
      endcase
      if (r.status != ST_WAIT) wait_over = 1'b1;
    end
    return r;
  endfunction

  // -------------------------------------------------------- driver / monitor

  always @(negedge clk) begin : feed
    req_word_t w;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || in_fire) begin
      if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
        w = feed_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.req_type   <= w.kind;
        req_if.char_value <= w.ch;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  always @(negedge clk) begin : drain_side
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      res_if.ready <= 1'b0;
      hold_used    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= req_if.valid && req_if.ready;
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result word with nothing expected: status %0d", res_if.status);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (res_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_if.status);
            fail_count++;
          end
          if (res_if.overflow !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, res_if.overflow);
            fail_count++;
          end
        end
      end
      // results are registered, so predict after the check
      if (req_if.valid && req_if.ready) begin
        verdict_q.push_back(match_step(req_t'(req_if.req_type), req_if.char_value));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_PAT_LOW:  mirror.pattern_low    = value;
      REG_PAT_HIGH: mirror.pattern_high   = value;
      REG_PAT_LEN:  mirror.pattern_length = value[4:0];
      REG_ONLINE:   mirror.online_mode    = value[0];
      REG_TIMEOUT:  mirror.timeout_ticks  = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic queue_word(req_t kind, logic [7:0] ch);
    req_word_t w;
    w.kind = kind;
    w.ch   = ch;
    feed_q.push_back(w);
    words_queued++;
  endtask

  // bit 7 is masked off by the block, so flip it freely
  task automatic queue_char(logic [7:0] ch);
    queue_word(REQ_CHAR, {ch[7] | ($urandom_range(3) == 0), ch[6:0]});
  endtask

  task automatic queue_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  function automatic logic [7:0] noise_char();
    if ($urandom_range(9) < 7) return alphabet[$urandom_range(alphabet.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  // never NUL, never the letter Z
  function automatic logic [7:0] quiet_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c[6:0] == 7'h00 || c[6:0] == 7'h5A);
    return c;
  endfunction

  task automatic drain();
    while (results_seen < words_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic gen_setup(setup_kind_t kind);
    logic [127:0] w;
    logic [63:0]  lenword;
    logic [63:0]  tmo;
    logic [63:0]  mode;
    int           n;
    int           i;
    int           j;
    w = {$urandom, $urandom, $urandom, $urandom};
    n = $urandom_range(16, 1);
    for (i = 0; i < n; i++) begin
      pat_txt[i] = alphabet[$urandom_range(alphabet.len() - 1)];
      w[i*8 +: 8] = pat_txt[i];
    end
    case ($urandom_range(9))
      0: begin
        // a byte with bit 7 set can never be matched
        j = $urandom_range(n - 1);
        pat_txt[j][7] = 1'b1;
        w[j*8 +: 8] = pat_txt[j];
      end
      1: begin
        j = $urandom_range(n - 1);
        w[j*8 +: 8] = 8'h00;
      end
      2: begin
        n = 2;
        pat_txt[0] = QUOTE_CHAR;
        pat_txt[1] = QUOTE_CHAR;
        w[15:0] = {QUOTE_CHAR, QUOTE_CHAR};
      end
      default: ;
    endcase
    pat_n   = n;
    lenword = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       lenword[4:0] = 5'd0;
      1:       lenword[4:0] = 5'($urandom_range(31, 17));
      2:       lenword[4:0] = 5'd16;
      default: lenword[4:0] = 5'(n);
    endcase
    tmo = {$urandom, $urandom};
    case (kind)
      SETUP_TIMEOUT_ONE: tmo[15:0] = 16'd1;
      SETUP_TIMEOUT_MAX: tmo[15:0] = 16'hFFFF;
      SETUP_TIMEOUT_OFF: tmo[15:0] = 16'd0;
      default:           tmo[15:0] = 16'($urandom_range(60, 4));
    endcase
    mode = {$urandom, $urandom};
    cfg_write(REG_PAT_LOW, w[63:0]);
    cfg_write(REG_PAT_HIGH, w[127:64]);
    cfg_write(REG_PAT_LEN, lenword);
    cfg_write(REG_ONLINE, mode);
    cfg_write(REG_TIMEOUT, tmo);
  endtask

  // mostly well-formed waits: a start, then noise, ticks and the text sought, FAILED CALL or a line error
  task automatic random_traffic(int count);
    int  target;
    int  seg;
    int  k;
    int  i;
    bit  wait_open;
    target = words_queued + count;
    while (words_queued < target) begin
      if ($urandom_range(9) != 0) queue_word(REQ_START, 8'($urandom_range(255)));
      seg       = $urandom_range(6, 1);
      k         = 0;
      wait_open = 1'b1;
      while (wait_open && k < seg && words_queued < target) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            for (i = $urandom_range(5, 1); i > 0; i--) queue_char(noise_char());
          end
          8, 9, 10, 11, 12: begin
            for (i = 0; i < pat_n; i++) queue_char(pat_txt[i]);
            wait_open = 1'b0;
          end
          13, 14: begin
            queue_text("FAILED CALL");
            wait_open = 1'b0;
          end
          15, 16, 17: begin
            for (i = $urandom_range(3, 1); i > 0; i--) begin
              queue_word(REQ_TICK, 8'($urandom_range(255)));
            end
          end
          18: begin
            queue_word(REQ_LINE_ERR, 8'($urandom_range(255)));
            wait_open = 1'b0;
          end
          default: queue_word(REQ_START, 8'($urandom_range(255)));
        endcase
        k++;
      end
    end
  endtask

  initial begin : script
    int          p;
    int          i;
    setup_kind_t kind;

    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = REQ_CHAR;
    req_if.char_value = 8'h00;
    res_if.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    calm              = 1'b0;
    hold_go           = 1'b0;

    mirror.pattern_low    = 64'd0;
    mirror.pattern_high   = 64'd0;
    mirror.pattern_length = PAT_LEN_RESET;
    mirror.online_mode    = 1'b0;
    mirror.timeout_ticks  = TIMEOUT_RESET;
    clear_wait();
    wait_over = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle before any start, then an empty pattern and NUL drops
    queue_word(REQ_CHAR, 8'hFF);
    queue_word(REQ_TICK, 8'h00);
    queue_word(REQ_START, 8'h00);
    queue_word(REQ_CHAR, 8'h00);
    queue_word(REQ_CHAR, 8'h80);
    queue_word(REQ_CHAR, 8'h7F);
    queue_word(REQ_START, 8'hFF);
    queue_word(REQ_LINE_ERR, 8'h55);
    drain();

    // "OK" with all-ones high bytes, online, short timeout
    cfg_write(REG_PAT_LOW, 64'h0000_0000_0000_4B4F);
    cfg_write(REG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(REG_PAT_LEN, 64'd2);
    cfg_write(REG_ONLINE, 64'd1);
    cfg_write(REG_TIMEOUT, 64'd2);
    queue_word(REQ_START, 8'h00);
    queue_word(REQ_CHAR, 8'hCF);
    queue_word(REQ_CHAR, 8'h4B);
    queue_word(REQ_START, 8'h00);
    queue_word(REQ_TICK, 8'h00);
    queue_word(REQ_TICK, 8'hFF);
    queue_word(REQ_START, 8'h00);
    queue_text("FAILED CALL");
    drain();

    // two quotes end the wait at start, also when cut short by a zero byte
    cfg_write(REG_PAT_LOW, 64'h0000_0000_0000_2222);
    queue_word(REQ_START, 8'h00);
    drain();
    cfg_write(REG_PAT_LEN, 64'd31);
    queue_word(REQ_START, 8'h00);
    queue_word(REQ_TICK, 8'h00);
    drain();

    for (p = 0; p < PHASES; p++) begin
      @(posedge clk);
      calm = (p == 1);
      if (p == 4) hold_go = 1'b1;
      case (p)
        3:       kind = SETUP_TIMEOUT_ONE;
        5:       kind = SETUP_TIMEOUT_MAX;
        6:       kind = SETUP_TIMEOUT_OFF;
        default: kind = SETUP_PLAIN;
      endcase
      gen_setup(kind);
      random_traffic(PHASE_WORDS);
      drain();
    end
    @(posedge clk);
    calm = 1'b0;

    // store limit: alone, against a match, and against FAILED CALL
    cfg_write(REG_PAT_LOW, 64'h0000_0000_0000_005A);
    cfg_write(REG_PAT_HIGH, {$urandom, $urandom});
    cfg_write(REG_PAT_LEN, 64'd1);
    cfg_write(REG_ONLINE, 64'd1);
    cfg_write(REG_TIMEOUT, 64'd0);
    queue_word(REQ_START, 8'h00);
    for (i = 0; i < 300; i++) queue_char(quiet_char());
    queue_word(REQ_START, 8'h00);
    for (i = 0; i < BUF_CHARS - 2; i++) queue_char(quiet_char());
    queue_char(8'h5A);
    queue_word(REQ_START, 8'h00);
    for (i = 0; i < BUF_CHARS - 1 - FAIL_LEN; i++) queue_char(quiet_char());
    queue_text("FAILED CALL");
    drain();

    repeat (8) @(negedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
